[sv/grid_min_path_cost_unit_defines.svh]
// ----------------------------------------------------------------------------
// grid_min_path_cost_unit assertion macros
// shared property shapes for the checker
// ----------------------------------------------------------------------------
`ifndef GRID_MIN_PATH_COST_UNIT_DEFINES_SVH
`define GRID_MIN_PATH_COST_UNIT_DEFINES_SVH

// antecedent and consequent in the same cycle
`define GMPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent in the cycle after the antecedent
`define GMPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/gmpc_pkg.sv]
// ----------------------------------------------------------------------------
// gmpc_pkg
// types and constants shared by the grid minimum path cost unit
// ----------------------------------------------------------------------------
`default_nettype none

package gmpc_pkg;

	localparam int COST_W     = 8;
	localparam int BEST_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int ROWS_CFG_W = 5;
	localparam int COLS_CFG_W = 7;
	localparam int STEP_CFG_W = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ROW_STEP = 2'd2;

	localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 5'd4;
	localparam logic [COLS_CFG_W-1:0] COLS_RESET = 7'd5;
	localparam logic [STEP_CFG_W-1:0] STEP_RESET = 4'd1;
	localparam logic [BEST_W-1:0]     BEST_MAX   = 16'hFFFF;

	typedef struct packed {
		logic load;    // take a cell and set up its window
		logic scan;    // read one previous-column entry
		logic finish;  // form the result, store it, step the counters
	} dp_cmd_t;

	typedef struct packed {
		logic col_zero;   // current cell is in the first column
		logic scan_last;  // read address is the top of the window
		logic out_free;   // result register can take a new result
	} dp_status_t;

endpackage

`default_nettype wire

[sv/gmpc_ram.sv]
// ----------------------------------------------------------------------------
// gmpc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module gmpc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

[sv/gmpc_ctrl.sv]
// ----------------------------------------------------------------------------
// gmpc_ctrl
// sequencer for one cell: accept, scan and drain (later columns only), result
// ----------------------------------------------------------------------------
`default_nettype none

module gmpc_ctrl
	import gmpc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cell_valid,
	output logic            cell_stall,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign cell_stall = (state_q != S_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (cell_valid) begin
					cmd.load = 1'b1;
					state_d  = status.col_zero ? S_FINISH : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			// last read data lands in the minimum here
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[sv/gmpc_dp.sv]
// ----------------------------------------------------------------------------
// gmpc_dp
// datapath: registers, counters, column store, window minimum, result register
// ----------------------------------------------------------------------------
`default_nettype none

module gmpc_dp
	import gmpc_pkg::*;
#(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	input  wire logic [COST_W-1:0]     cell_cost,
	input  wire dp_cmd_t               cmd,
	output dp_status_t                 status,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic      [BEST_W-1:0]     best_cost,
	output logic                       grid_done,
	output logic      [BEST_W-1:0]     total_min
);

	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RXW = ($clog2(MAX_ROWS + 1) > ROWS_CFG_W) ? $clog2(MAX_ROWS + 1) : ROWS_CFG_W;
	localparam int CXW = ($clog2(MAX_COLS + 1) > COLS_CFG_W) ? $clog2(MAX_COLS + 1) : COLS_CFG_W;
	localparam int SW  = ((RW > STEP_CFG_W) ? RW : STEP_CFG_W) + 1;
	localparam int AW  = RW + 1;

	// configuration
	logic [ROWS_CFG_W-1:0] rows_in_use_q;
	logic [COLS_CFG_W-1:0] cols_in_use_q;
	logic [STEP_CFG_W-1:0] max_row_step_q;
	logic                  cfg_hit;

	// grid position
	logic [RW-1:0]     row_q;
	logic [CW-1:0]     col_q;
	logic              bank_q;
	logic [BEST_W-1:0] running_min_q;

	// per cell working registers
	logic [COST_W-1:0] cost_q;
	logic              first_q;
	logic [RW-1:0]     idx_q;
	logic [RW-1:0]     hi_q;
	logic [BEST_W-1:0] min_q;
	logic              acc_v_s1;

	logic [RXW-1:0] rows_x;
	logic [RXW-1:0] rows_eff;
	logic [CXW-1:0] cols_x;
	logic [CXW-1:0] cols_eff;
	logic [RW-1:0]  row_last;
	logic [CW-1:0]  col_last;

	logic [SW-1:0]     row_x;
	logic [SW-1:0]     step_x;
	logic [SW-1:0]     hi_raw;
	logic [RW-1:0]     lo_d;
	logic [RW-1:0]     hi_d;
	logic [BEST_W:0]   sum;
	logic [BEST_W-1:0] best;
	logic              last_row;
	logic              last_col;
	logic [BEST_W-1:0] run_min_d;
	logic [BEST_W-1:0] rd_data;

	assign cfg_hit = wr_en && (wr_index == REG_ROWS_IN_USE || wr_index == REG_COLS_IN_USE
		|| wr_index == REG_MAX_ROW_STEP);

	// counts of zero act as one, counts above MAX_ROWS or MAX_COLS clamp to that limit
	assign rows_x   = RXW'(rows_in_use_q);
	assign rows_eff = (rows_x == '0) ? RXW'(1) :
		((rows_x > RXW'(MAX_ROWS)) ? RXW'(MAX_ROWS) : rows_x);
	assign row_last = RW'(rows_eff - RXW'(1));
	assign cols_x   = CXW'(cols_in_use_q);
	assign cols_eff = (cols_x == '0) ? CXW'(1) :
		((cols_x > CXW'(MAX_COLS)) ? CXW'(MAX_COLS) : cols_x);
	assign col_last = CW'(cols_eff - CXW'(1));

	// window bounds for the row being accepted
	assign row_x  = SW'(row_q);
	assign step_x = SW'(max_row_step_q);
	assign lo_d   = (row_x > step_x) ? RW'(row_x - step_x) : '0;
	assign hi_raw = row_x + step_x;
	assign hi_d   = (hi_raw > SW'(row_last)) ? row_last : RW'(hi_raw);

	assign sum  = {1'b0, min_q} + (BEST_W + 1)'(cost_q);
	assign best = first_q ? BEST_W'(cost_q) : (sum[BEST_W] ? BEST_MAX : sum[BEST_W-1:0]);

	assign last_row  = (row_q == row_last);
	assign last_col  = (col_q == col_last);
	assign run_min_d = (last_col && best < running_min_q) ? best : running_min_q;

	assign status.col_zero  = (col_q == '0);
	assign status.scan_last = (idx_q == hi_q);
	assign status.out_free  = !result_valid || !result_stall;

	// two banks: current column written, previous column read
	gmpc_ram #(
		.WIDTH (BEST_W),
		.DEPTH (1 << AW)
	) u_col_ram (
		.clk     (clk),
		.wr_en   (cmd.finish),
		.wr_addr ({bank_q, row_q}),
		.wr_data (best),
		.rd_addr ({~bank_q, idx_q}),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q  <= ROWS_RESET;
			cols_in_use_q  <= COLS_RESET;
			max_row_step_q <= STEP_RESET;
			row_q          <= '0;
			col_q          <= '0;
			bank_q         <= 1'b0;
			running_min_q  <= BEST_MAX;
			acc_v_s1       <= 1'b0;
			result_valid   <= 1'b0;
		end else begin
			acc_v_s1 <= cmd.scan;
			if (cmd.finish) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
			if (cfg_hit) begin
				case (wr_index)
					REG_ROWS_IN_USE:  rows_in_use_q  <= wr_data[ROWS_CFG_W-1:0];
					REG_COLS_IN_USE:  cols_in_use_q  <= wr_data[COLS_CFG_W-1:0];
					REG_MAX_ROW_STEP: max_row_step_q <= wr_data[STEP_CFG_W-1:0];
					default: begin
					end
				endcase
				// any register write restarts the grid
				row_q         <= '0;
				col_q         <= '0;
				running_min_q <= BEST_MAX;
			end else if (cmd.finish) begin
				if (last_row) begin
					row_q  <= '0;
					bank_q <= ~bank_q;
					if (last_col) begin
						col_q         <= '0;
						running_min_q <= BEST_MAX;
					end else begin
						col_q         <= col_q + CW'(1);
						running_min_q <= run_min_d;
					end
				end else begin
					row_q         <= row_q + RW'(1);
					running_min_q <= run_min_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cost_q  <= cell_cost;
			first_q <= (col_q == '0);
			idx_q   <= lo_d;
			hi_q    <= hi_d;
			min_q   <= BEST_MAX;
		end else begin
			if (cmd.scan) begin
				idx_q <= idx_q + RW'(1);
			end
			if (acc_v_s1 && rd_data < min_q) begin
				min_q <= rd_data;
			end
		end
		if (cmd.finish) begin
			best_cost <= best;
			grid_done <= last_row && last_col;
			total_min <= (last_row && last_col) ? run_min_d : '0;
		end
	end

endmodule

`default_nettype wire

[sv/grid_min_path_cost_unit.sv]
// ----------------------------------------------------------------------------
// grid_min_path_cost_unit
// minimum cost path through a grid, best costs of two columns kept at a time
// ----------------------------------------------------------------------------
// cells arrive on cell_cost/cell_valid/cell_stall in column-major order and
// each transfer gives exactly one result on best_cost, grid_done, total_min
// with result_valid/result_stall. grid_done marks the last cell of a grid,
// and total_min then holds the minimum over the last column (zero otherwise).
// a first-column cell goes from the transfer straight to the finish state;
// a later cell scans its previous-column window (up to 2*max_row_step+1 rows,
// clipped at the grid edges) and passes a drain state. the window is read one
// entry a cycle from the single read port of the column ram, which sets the
// rate; cell_stall is high from the transfer until the result is registered.
// the result register lets the next cell be taken while a result waits; a
// held result_stall keeps the result and holds the next cell in its last
// cycle until the register frees. reset restores rows 4, columns 5, step 1
// and the start of a grid; a wr_en write to index 0-2 also restarts the grid.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_min_path_cost_unit
	import gmpc_pkg::*;
#(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	input  wire logic                  cell_valid,
	output logic                       cell_stall,
	input  wire logic [COST_W-1:0]     cell_cost,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic      [BEST_W-1:0]     best_cost,
	output logic                       grid_done,
	output logic      [BEST_W-1:0]     total_min
);

	dp_cmd_t    cmd;
	dp_status_t status;

	gmpc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.status     (status),
		.cmd        (cmd)
	);

	gmpc_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.cell_cost    (cell_cost),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.best_cost    (best_cost),
		.grid_done    (grid_done),
		.total_min    (total_min)
	);

endmodule

`default_nettype wire

[sv/gmpc_checker.sv]
// ----------------------------------------------------------------------------
// gmpc_checker
// port-level checks for the grid minimum path cost unit
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_min_path_cost_unit_defines.svh"

module gmpc_checker
	import gmpc_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cell_valid,
	input wire logic              cell_stall,
	input wire logic              result_valid,
	input wire logic              result_stall,
	input wire logic [BEST_W-1:0] best_cost,
	input wire logic              grid_done,
	input wire logic [BEST_W-1:0] total_min
);

	// a stalled result holds still
	`GMPC_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(best_cost) && $stable(grid_done) && $stable(total_min), "stalled result changed")

	// total is only shown with the last cell of a grid
	`GMPC_ASSERT_SAME(a_total_zero, clk, arst_n, result_valid && !grid_done, total_min == '0, "total_min nonzero without grid_done")

	// one cell at a time: input closes right after a transfer
	`GMPC_ASSERT_NEXT(a_busy_after_transfer, clk, arst_n, cell_valid && !cell_stall, cell_stall, "second cell taken while busy")

	// a new result comes with the input open again
	`GMPC_ASSERT_SAME(a_ready_with_result, clk, arst_n, $rose(result_valid), !cell_stall, "input still closed after result")

endmodule

bind grid_min_path_cost_unit gmpc_checker u_gmpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cell_valid   (cell_valid),
	.cell_stall   (cell_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.best_cost    (best_cost),
	.grid_done    (grid_done),
	.total_min    (total_min)
);

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for grid_min_path_cost_unit
// drives grid cells and register writes, predicts every cell's best cost,
// the end-of-grid flag and the last-column minimum, and checks each result
// transfer in order against that prediction or the typed directed value
// ----------------------------------------------------------------------------

module testbench
	import gmpc_pkg::*;
();

	localparam int ROWS_MAX     = 16;
	localparam int COLS_MAX     = 64;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_AFTER   = 400;
	localparam int HOLD_CYCLES  = 200;
	localparam int PHASES       = 9;
	localparam int DIR_ROWS     = 25;

	// index past the register list, writes to it are ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [BEST_W-1:0] best;
		logic              done;
		logic [BEST_W-1:0] total;
	} path_result_t;

	typedef enum logic {DIR_CELL, DIR_WRITE} dir_kind_t;

	typedef struct packed {
		dir_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [COST_W-1:0]     cost;
		logic                  typed;
		path_result_t          want;
	} dir_row_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] rows;
		logic [CFG_DATA_W-1:0] cols;
		logic [CFG_DATA_W-1:0] step;
		logic                  pick_random;
		logic [11:0]           items;
	} phase_cfg_t;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  wr_en        = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index     = '0;
	logic [CFG_DATA_W-1:0] wr_data      = '0;
	logic                  cell_valid   = 1'b0;
	logic                  cell_stall;
	logic [COST_W-1:0]     cell_cost    = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [BEST_W-1:0]     best_cost;
	logic                  grid_done;
	logic [BEST_W-1:0]     total_min;

	// predictor state
	logic [ROWS_CFG_W-1:0] cfg_rows = ROWS_RESET;
	logic [COLS_CFG_W-1:0] cfg_cols = COLS_RESET;
	logic [STEP_CFG_W-1:0] cfg_step = STEP_RESET;
	logic [BEST_W-1:0]     prev_col [ROWS_MAX];
	logic [BEST_W-1:0]     this_col [ROWS_MAX];
	int unsigned           row_pos  = 0;
	int unsigned           col_pos  = 0;
	logic [BEST_W-1:0]     run_min  = BEST_MAX;

	path_result_t expected_paths [$];

	int unsigned send_idle_pct   = 30;
	int unsigned recv_idle_pct   = 55;
	int unsigned cells_sent      = 0;
	int unsigned results_checked = 0;
	int unsigned grids_finished  = 0;
	int unsigned mismatches      = 0;
	int unsigned cycle_count     = 0;
	int unsigned hold_left       = 0;
	logic        hold_used       = 1'b0;

	dir_row_t dir_rows [DIR_ROWS] = '{
		// reset setting: 4 rows, 5 columns, step 1; first column is the cost itself
		'{DIR_CELL,  REG_UNUSED,       7'h00, 8'hFF, 1'b1, '{16'h00FF, 1'b0, 16'h0000}},
		'{DIR_CELL,  REG_UNUSED,       7'h00, 8'h00, 1'b1, '{16'h0000, 1'b0, 16'h0000}},
		'{DIR_CELL,  REG_UNUSED,       7'h00, 8'h80, 1'b1, '{16'h0080, 1'b0, 16'h0000}},
		'{DIR_CELL,  REG_UNUSED,       7'h00, 8'h01, 1'b1, '{16'h0001, 1'b0, 16'h0000}},
		'{DIR_CELL,  REG_UNUSED,       7'h00, 8'h10, 1'b0, '0},
		'{DIR_CELL,  REG_UNUSED,       7'h00, 8'hFF, 1'b0, '0},
		'{DIR_CELL,  REG_UNUSED,       7'h00, 8'h00, 1'b0, '0},
		'{DIR_CELL,  REG_UNUSED,       7'h00, 8'h7F, 1'b0, '0},
		// write past the register list must leave the grid running
		'{DIR_WRITE, REG_UNUSED,       7'h7F, 8'h00, 1'b0, '0},
		'{DIR_CELL,  REG_UNUSED,       7'h00, 8'h01, 1'b0, '0},
		'{DIR_CELL,  REG_UNUSED,       7'h00, 8'hFE, 1'b0, '0},
		// zero rows and columns act as one: every cell closes a grid
		'{DIR_WRITE, REG_ROWS_IN_USE,  7'h00, 8'h00, 1'b0, '0},
		'{DIR_WRITE, REG_COLS_IN_USE,  7'h00, 8'h00, 1'b0, '0},
		'{DIR_WRITE, REG_MAX_ROW_STEP, 7'h00, 8'h00, 1'b0, '0},
		'{DIR_CELL,  REG_UNUSED,       7'h00, 8'hFF, 1'b1, '{16'h00FF, 1'b1, 16'h00FF}},
		'{DIR_CELL,  REG_UNUSED,       7'h00, 8'h00, 1'b1, '{16'h0000, 1'b1, 16'h0000}},
		// widest step, window clipped at both grid edges
		'{DIR_WRITE, REG_ROWS_IN_USE,  7'h03, 8'h00, 1'b0, '0},
		'{DIR_WRITE, REG_COLS_IN_USE,  7'h02, 8'h00, 1'b0, '0},
		'{DIR_WRITE, REG_MAX_ROW_STEP, 7'h0F, 8'h00, 1'b0, '0},
		'{DIR_CELL,  REG_UNUSED,       7'h00, 8'h20, 1'b0, '0},
		'{DIR_CELL,  REG_UNUSED,       7'h00, 8'h80, 1'b0, '0},
		'{DIR_CELL,  REG_UNUSED,       7'h00, 8'hFF, 1'b0, '0},
		'{DIR_CELL,  REG_UNUSED,       7'h00, 8'h00, 1'b0, '0},
		'{DIR_CELL,  REG_UNUSED,       7'h00, 8'h05, 1'b0, '0},
		'{DIR_CELL,  REG_UNUSED,       7'h00, 8'h40, 1'b0, '0}
	};

	// rows and columns as raw register values, so masking and clamping get exercised
	phase_cfg_t phases [PHASES] = '{
		'{7'd2,   7'd3,   7'd0,   1'b0, 12'd200},
		'{7'd16,  7'd4,   7'd15,  1'b0, 12'd200},
		'{7'h7F,  7'd2,   7'd7,   1'b0, 12'd200},
		'{7'd1,   7'h7F,  7'd0,   1'b0, 12'd150},
		'{7'd0,   7'd0,   7'h7F,  1'b0, 12'd200},
		'{7'd0,   7'd0,   7'd0,   1'b1, 12'd200},
		'{7'd3,   7'd65,  7'd2,   1'b0, 12'd250},
		'{7'd0,   7'd0,   7'd0,   1'b1, 12'd200},
		'{7'd17,  7'd5,   7'd1,   1'b0, 12'd200}
	};

	grid_min_path_cost_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.cell_valid   (cell_valid),
		.cell_stall   (cell_stall),
		.cell_cost    (cell_cost),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.best_cost    (best_cost),
		.grid_done    (grid_done),
		.total_min    (total_min)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void begin_new_grid();
		row_pos = 0;
		col_pos = 0;
		run_min = BEST_MAX;
	endfunction

	function automatic path_result_t predict_path(input logic [COST_W-1:0] cost);
		int unsigned rows, cols, r, c, lo, hi, i, low_cost, sum;
		path_result_t res;
		rows = (cfg_rows == 0) ? 1 : ((cfg_rows > ROWS_MAX) ? ROWS_MAX : cfg_rows);
		cols = (cfg_cols == 0) ? 1 : ((cfg_cols > COLS_MAX) ? COLS_MAX : cfg_cols);
		if (row_pos >= rows) row_pos = 0;
		if (col_pos >= cols) col_pos = 0;
		r = row_pos;
		c = col_pos;
		if (c == 0) begin
			sum = cost;
		end else begin
			lo = (r > cfg_step) ? r - cfg_step : 0;
			hi = (r + cfg_step > rows - 1) ? rows - 1 : r + cfg_step;
			low_cost = 32'hFFFF_FFFF;
			for (i = lo; i <= hi; i++)
				if (prev_col[i] < low_cost) low_cost = prev_col[i];
			sum = low_cost + cost;
			if (sum > BEST_MAX) sum = BEST_MAX;
		end
		res.best  = BEST_W'(sum);
		res.done  = 1'b0;
		res.total = '0;
		this_col[r] = res.best;
		if (c == cols - 1 && res.best < run_min) run_min = res.best;
		row_pos = r + 1;
		if (row_pos >= rows) begin
			row_pos  = 0;
			prev_col = this_col;
			col_pos  = c + 1;
			if (col_pos >= cols) begin
				res.done  = 1'b1;
				res.total = run_min;
				begin_new_grid();
			end
		end
		return res;
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic drive_cell(input logic [COST_W-1:0] cost, input logic typed,
			input path_result_t want);
		path_result_t res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cell_valid <= 1'b0;
			@(negedge clk);
		end
		cell_valid <= 1'b1;
		cell_cost  <= cost;
		@(posedge clk);
		while (cell_stall) @(posedge clk);
		res = predict_path(cost);
		expected_paths.push_back(typed ? want : res);
		cells_sent++;
		@(negedge clk);
	endtask

	// stop offering cells and let the block run dry
	task automatic settle();
		cell_valid <= 1'b0;
		while (expected_paths.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
		case (idx)
			REG_ROWS_IN_USE:  cfg_rows = data[ROWS_CFG_W-1:0];
			REG_COLS_IN_USE:  cfg_cols = data[COLS_CFG_W-1:0];
			REG_MAX_ROW_STEP: cfg_step = data[STEP_CFG_W-1:0];
			default: ;
		endcase
		if (idx != REG_UNUSED) begin_new_grid();
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10) $display("mismatch at result %0d: %s", results_checked, what);
	endtask

	// result checking
	always @(posedge clk) begin
		path_result_t got, want;
		if (arst_n && result_valid && !result_stall) begin
			got = '{best_cost, grid_done, total_min};
			if (expected_paths.size() == 0) begin
				flag_mismatch($sformatf("unexpected transfer best %0d done %0b total %0d",
					got.best, got.done, got.total));
			end else begin
				want = expected_paths.pop_front();
				if (got.best !== want.best)
					flag_mismatch($sformatf("best_cost expected %0d got %0d",
						want.best, got.best));
				if (got.done !== want.done)
					flag_mismatch($sformatf("grid_done expected %0b got %0b",
						want.done, got.done));
				if (got.total !== want.total)
					flag_mismatch($sformatf("total_min expected %0d got %0d",
						want.total, got.total));
			end
			results_checked++;
			if (got.done) grids_finished++;
		end
	end

	// receiver stalls, with one long hold-off so the block backs up into its input
	always @(negedge clk) begin
		if (!hold_used && results_checked >= HOLD_AFTER) begin
			hold_used = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("grid_min_path_cost_unit verification failed");
		$finish;
	end

	initial begin
		phase_cfg_t           cfg;
		int                   k, p, n;
		logic [CFG_IDX_W-1:0] reg_pick;
		logic [CFG_DATA_W-1:0] reg_val;
		logic [COST_W-1:0]    cost;

		foreach (prev_col[k]) begin
			prev_col[k] = '0;
			this_col[k] = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (k = 0; k < DIR_ROWS; k++) begin
			if (dir_rows[k].kind == DIR_WRITE) begin
				settle();
				write_reg(dir_rows[k].idx, dir_rows[k].data);
			end else begin
				drive_cell(dir_rows[k].cost, dir_rows[k].typed, dir_rows[k].want);
			end
		end

		for (p = 0; p < PHASES; p++) begin
			cfg = phases[p];
			if (cfg.pick_random) begin
				cfg.rows = CFG_DATA_W'($urandom_range(0, 127));
				cfg.cols = CFG_DATA_W'($urandom_range(1, 12));
				cfg.step = CFG_DATA_W'($urandom_range(0, 127));
				// keep grids small so several finish in the phase
				cfg.rows[ROWS_CFG_W-1:3] = '0;
			end
			case (p / 3)
				0: begin
					send_idle_pct = 30;
					recv_idle_pct = 55;
				end
				1: begin
					send_idle_pct = 55;
					recv_idle_pct = 30;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			settle();
			write_reg(REG_ROWS_IN_USE, cfg.rows);
			write_reg(REG_COLS_IN_USE, cfg.cols);
			write_reg(REG_MAX_ROW_STEP, cfg.step);
			for (n = 0; n < cfg.items; n++) begin
				// now and then drop a partial grid with a register write
				if ($urandom_range(0, 149) == 0) begin
					settle();
					reg_pick = CFG_IDX_W'($urandom_range(0, 3));
					case (reg_pick)
						REG_ROWS_IN_USE:  reg_val = cfg.rows;
						REG_COLS_IN_USE:  reg_val = cfg.cols;
						REG_MAX_ROW_STEP: reg_val = cfg.step;
						default:          reg_val = CFG_DATA_W'($urandom_range(0, 127));
					endcase
					write_reg(reg_pick, reg_val);
				end
				if ($urandom_range(0, 9) == 0)
					cost = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
				else
					cost = COST_W'($urandom_range(0, 255));
				drive_cell(cost, 1'b0, '0);
			end
		end

		settle();
		$display("run covered %0d cells in %0d register settings, %0d grids finished",
			cells_sent, PHASES + 3, grids_finished);
		$display("%0d result transfers checked in %0d cycles, %0d mismatches",
			results_checked, cycle_count, mismatches);
		if (mismatches == 0 && expected_paths.size() == 0)
			$display("grid_min_path_cost_unit verification clean");
		else
			$display("grid_min_path_cost_unit verification failed");
		$finish;
	end

endmodule
